// ===== sv/ethernet_vlan_mpls_classifier_assert.svh =====
// Assertion macros for the classifier RTL.
// Used by the classifier modules; expects clk and rst_n in scope.
`ifndef ETHERNET_VLAN_MPLS_CLASSIFIER_ASSERT_SVH
`define ETHERNET_VLAN_MPLS_CLASSIFIER_ASSERT_SVH

`ifndef SYNTH
`define EVMC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("evmc assertion failed");
`define EVMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("evmc assertion failed");
`else
`define EVMC_ASSERT_NOW(label, ante, cons)
`define EVMC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/evmc_pkg.sv =====
// Shared types and constants for the Ethernet/VLAN/MPLS classifier.
// No dependencies.
package evmc_pkg;

    localparam int MAX_FRAME_BYTES = 16383;
    localparam int MAX_LABELS      = 16;

    localparam logic [13:0] POS_MAX = 14'd16383;
    localparam logic [13:0] LEN_CAP =
        (MAX_FRAME_BYTES < 16383) ? 14'(MAX_FRAME_BYTES) : 14'd16383;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] TYPE_VLAN  = 16'h8100;
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] TYPE_ARP   = 16'h0806;
    localparam logic [15:0] TYPE_MPLS  = 16'h8847;
    localparam logic [15:0] TYPE_MPLSM = 16'h8848;
    localparam logic [3:0]  IPV4_VER   = 4'h4;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_IPV4 = 2'd1;
    localparam logic [1:0] CLS_ARP  = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_SHORT = 2'd1;
    localparam logic [1:0] STS_TRUNC = 2'd2;
    localparam logic [1:0] STS_DEEP  = 2'd3;

    typedef enum logic [2:0] {
        PH_ETH,
        PH_VLAN,
        PH_MPLS,
        PH_VER,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } evmc_in_t;

    typedef struct packed {
        logic [1:0]  hook_class;
        logic [13:0] payload_offset;
        logic [13:0] payload_length;
        logic [15:0] ether_type;
        logic        vlan_tagged;
        logic [4:0]  label_count;
        logic [1:0]  status;
    } evmc_out_t;

    // per-frame summary handed from parser to output stage
    typedef struct packed {
        logic [1:0]  hook_class;
        logic [13:0] payload_offset;
        logic [13:0] frame_len;
        logic [15:0] ether_type;
        logic        vlan_tagged;
        logic [4:0]  label_count;
        logic [1:0]  status;
    } evmc_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } evmc_q_stat_t;

endpackage

// ===== sv/evmc_front.sv =====
// Byte-serial header parser: tracks Ethernet, VLAN and MPLS fields per frame.
// Depends on evmc_pkg; pushes one summary per frame into the request queue.
`include "ethernet_vlan_mpls_classifier_assert.svh"
module evmc_front
    import evmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  evmc_in_t     in_data,
    input  evmc_q_stat_t q_stat,
    output logic         push,
    output evmc_rec_t    push_rec
);

    logic [13:0] pos_reg, pos_next;
    phase_t      phase_reg, phase_next, phase_parse;
    logic [15:0] type_reg, type_next;
    logic [7:0]  held_reg, held_next;
    logic        tag_reg, tag_next;
    logic [4:0]  labels_reg, labels_next;
    logic [13:0] start_reg, start_next;
    logic [1:0]  class_reg, class_next;
    logic [1:0]  err_reg, err_next;

    logic        accept;
    logic        last;
    logic [15:0] cur_type;
    logic        eth_type_pos;
    logic        vlan_type_pos;
    logic        mpls_hit;
    logic        ver_hit;
    logic        stack_full;
    logic [13:0] len_raw;
    logic        short_frame;

    function automatic phase_t phase_for_type(input logic [15:0] t);
        if (t == TYPE_MPLS || t == TYPE_MPLSM)
            return PH_MPLS;
        return PH_DONE;
    endfunction

    function automatic logic [1:0] class_for_type(input logic [15:0] t);
        if (t == TYPE_IPV4)
            return CLS_IPV4;
        if (t == TYPE_ARP)
            return CLS_ARP;
        return CLS_NONE;
    endfunction

    assign in_ready      = !q_stat.full;
    assign accept        = in_valid && in_ready;
    assign last          = in_data.last_byte;
    assign cur_type      = {held_reg, in_data.data_byte};
    assign eth_type_pos  = (phase_reg == PH_ETH) && (pos_reg == 14'd13);
    assign vlan_type_pos = (phase_reg == PH_VLAN) && (pos_reg == 14'd17);
    assign mpls_hit      = (phase_reg == PH_MPLS) && (pos_reg == start_reg + 14'd2);
    assign ver_hit       = (phase_reg == PH_VER) && (pos_reg == start_reg);
    assign stack_full    = (labels_reg + 5'd1) >= 5'(MAX_LABELS);

    // next parse phase
    always_comb
    begin
        phase_parse = phase_reg;
        unique case (phase_reg)
            PH_ETH:
            begin
                if (pos_reg == 14'd13)
                    phase_parse = (cur_type == TYPE_VLAN) ? PH_VLAN : phase_for_type(cur_type);
            end
            PH_VLAN:
            begin
                if (pos_reg == 14'd17)
                    phase_parse = phase_for_type(cur_type);
            end
            PH_MPLS:
            begin
                if (mpls_hit)
                begin
                    if (in_data.data_byte[0])
                        phase_parse = PH_VER;
                    else if (stack_full)
                        phase_parse = PH_DONE;
                end
            end
            PH_VER:
            begin
                if (ver_hit)
                    phase_parse = PH_DONE;
            end
            PH_DONE:
                phase_parse = PH_DONE;
            default:
                phase_parse = PH_DONE;
        endcase
        phase_next = phase_reg;
        if (accept)
            phase_next = last ? PH_ETH : phase_parse;
    end

    // header fields after this byte
    always_comb
    begin
        pos_next    = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 14'd1;
        type_next   = type_reg;
        held_next   = held_reg;
        tag_next    = tag_reg;
        labels_next = labels_reg;
        start_next  = start_reg;
        class_next  = class_reg;
        err_next    = err_reg;
        if ((phase_reg == PH_ETH && pos_reg == 14'd12) ||
            (phase_reg == PH_VLAN && pos_reg == 14'd16))
            held_next = in_data.data_byte;
        if (eth_type_pos)
        begin
            type_next = cur_type;
            if (cur_type == TYPE_VLAN)
            begin
                tag_next   = 1'b1;
                start_next = 14'd18;
            end
            else
            begin
                start_next = 14'd14;
                class_next = class_for_type(cur_type);
            end
        end
        if (vlan_type_pos)
        begin
            type_next  = cur_type;
            class_next = class_for_type(cur_type);
        end
        if (mpls_hit)
        begin
            labels_next = labels_reg + 5'd1;
            start_next  = start_reg + 14'd4;
            if (!in_data.data_byte[0] && stack_full)
                err_next = STS_DEEP;
        end
        if (ver_hit && in_data.data_byte[7:4] == IPV4_VER)
            class_next = CLS_IPV4;
    end

    // frame summary on the last byte
    always_comb
    begin
        len_raw     = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 14'd1;
        short_frame = pos_reg < 14'd13;
        push        = accept && last;
        if (short_frame)
        begin
            push_rec        = '0;
            push_rec.status = STS_SHORT;
        end
        else
        begin
            push_rec.hook_class     = (phase_parse == PH_DONE) ? class_next : CLS_NONE;
            push_rec.payload_offset = start_next;
            push_rec.frame_len      = (len_raw > LEN_CAP) ? LEN_CAP : len_raw;
            push_rec.ether_type     = type_next;
            push_rec.vlan_tagged    = tag_next;
            push_rec.label_count    = labels_next;
            push_rec.status         = (phase_parse == PH_DONE) ? err_next : STS_TRUNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_ETH;
            type_reg   <= '0;
            held_reg   <= '0;
            tag_reg    <= 1'b0;
            labels_reg <= '0;
            start_reg  <= '0;
            class_reg  <= CLS_NONE;
            err_reg    <= STS_OK;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            if (last)
            begin
                pos_reg    <= '0;
                type_reg   <= '0;
                held_reg   <= '0;
                tag_reg    <= 1'b0;
                labels_reg <= '0;
                start_reg  <= '0;
                class_reg  <= CLS_NONE;
                err_reg    <= STS_OK;
            end
            else
            begin
                pos_reg    <= pos_next;
                type_reg   <= type_next;
                held_reg   <= held_next;
                tag_reg    <= tag_next;
                labels_reg <= labels_next;
                start_reg  <= start_next;
                class_reg  <= class_next;
                err_reg    <= err_next;
            end
        end
    end

    `EVMC_ASSERT_NEXT(a_frame_restart, accept && last, pos_reg == 14'd0 && phase_reg == PH_ETH)
    `EVMC_ASSERT_NOW(a_label_bound, 1'b1, labels_reg <= 5'(MAX_LABELS))

endmodule

// ===== sv/evmc_fifo.sv =====
// Small request queue between parser and output stage.
// Depends on evmc_pkg for the record type and depth.
`include "ethernet_vlan_mpls_classifier_assert.svh"
module evmc_fifo
    import evmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  evmc_rec_t    push_rec,
    input  logic         pop,
    output evmc_rec_t    pop_rec,
    output evmc_q_stat_t q_stat
);

    evmc_rec_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == FIFO_CW'(FIFO_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign pop_rec      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + FIFO_AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + FIFO_AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + FIFO_CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    `EVMC_ASSERT_NOW(a_no_overflow, push, !q_stat.full)
    `EVMC_ASSERT_NOW(a_no_underflow, pop, !q_stat.empty)
    `EVMC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= FIFO_CW'(FIFO_DEPTH))

endmodule

// ===== sv/evmc_back.sv =====
// Output stage: finishes payload length and holds the result register.
// Depends on evmc_pkg; drains the request queue.
`include "ethernet_vlan_mpls_classifier_assert.svh"
module evmc_back
    import evmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  evmc_rec_t    q_rec,
    input  evmc_q_stat_t q_stat,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output evmc_out_t    out_data
);

    logic      out_valid_reg, out_valid_next;
    evmc_out_t out_data_reg;
    evmc_out_t result;

    assign pop = !q_stat.empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        result.hook_class     = q_rec.hook_class;
        result.payload_offset = q_rec.payload_offset;
        result.payload_length = (q_rec.frame_len > q_rec.payload_offset) ?
                                q_rec.frame_len - q_rec.payload_offset : '0;
        result.ether_type     = q_rec.ether_type;
        result.vlan_tagged    = q_rec.vlan_tagged;
        result.label_count    = q_rec.label_count;
        result.status         = q_rec.status;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `EVMC_ASSERT_NOW(a_short_zero, out_valid_reg && out_data_reg.status == STS_SHORT,
                     out_data_reg.payload_offset == '0 && out_data_reg.label_count == '0)

endmodule

// ===== sv/ethernet_vlan_mpls_classifier.sv =====
// Top level of the Ethernet/VLAN/MPLS header classifier.
// Depends on evmc_pkg, evmc_front, evmc_fifo and evmc_back.
//
// Accepts one frame byte per clock while in_ready is high and returns one
// classification result per frame. The result is written into a 4-entry queue
// at the edge that takes the last byte and moves into the output register once
// that register is empty or being taken. The parser keeps pace with the byte
// stream; in_ready drops only while the queue is full, i.e. when four results
// wait behind the one held at a stalled output.
module ethernet_vlan_mpls_classifier
    import evmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  evmc_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output evmc_out_t out_data
);

    evmc_q_stat_t q_stat;
    evmc_rec_t    push_rec;
    evmc_rec_t    pop_rec;
    logic         push;
    logic         pop;

    evmc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_rec (push_rec)
    );

    evmc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .q_stat   (q_stat)
    );

    evmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rec     (pop_rec),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for ethernet_vlan_mpls_classifier.
// Streams Ethernet, VLAN and MPLS frames byte by byte and checks each frame result.
// Depends on evmc_pkg and the classifier RTL.
module testbench;
    import evmc_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int ITEM_TARGET   = 700;
    localparam int RANDOM_FRAMES = 6;

    class frame_scoreboard;
        phase_t      stage;
        logic [13:0] byte_idx;
        logic [15:0] frame_type;
        logic [7:0]  type_hi;
        logic        vlan_seen;
        logic [4:0]  label_cnt;
        int          hdr_end;
        logic [1:0]  cls;
        logic [1:0]  err;
        evmc_out_t   expected_q[$];
        int          errors;
        int          results_checked;
        int          status_cnt[4];
        int          vlan_cnt;
        int          mpls_cnt;

        function new();
            clear_frame();
        endfunction

        function void clear_frame();
            stage      = PH_ETH;
            byte_idx   = '0;
            frame_type = '0;
            type_hi    = '0;
            vlan_seen  = 1'b0;
            label_cnt  = '0;
            hdr_end    = 0;
            cls        = CLS_NONE;
            err        = STS_OK;
        endfunction

        function void classify_type();
            if (frame_type == TYPE_IPV4)
            begin
                cls   = CLS_IPV4;
                stage = PH_DONE;
            end
            else if (frame_type == TYPE_ARP)
            begin
                cls   = CLS_ARP;
                stage = PH_DONE;
            end
            else if (frame_type == TYPE_MPLS || frame_type == TYPE_MPLSM)
                stage = PH_MPLS;
            else
                stage = PH_DONE;
        endfunction

        function void parse_header_byte(int p, logic [7:0] b);
            case (stage)
                PH_ETH:
                begin
                    if (p == 12)
                        type_hi = b;
                    else if (p == 13)
                    begin
                        frame_type = {type_hi, b};
                        if (frame_type == TYPE_VLAN)
                        begin
                            vlan_seen = 1'b1;
                            hdr_end   = 18;
                            stage     = PH_VLAN;
                        end
                        else
                        begin
                            hdr_end = 14;
                            classify_type();
                        end
                    end
                end
                PH_VLAN:
                begin
                    if (p == 16)
                        type_hi = b;
                    else if (p == 17)
                    begin
                        frame_type = {type_hi, b};
                        classify_type();
                    end
                end
                PH_MPLS:
                begin
                    // third byte of each label carries bottom-of-stack
                    if (p == hdr_end + 2)
                    begin
                        label_cnt++;
                        hdr_end += 4;
                        if (b[0])
                            stage = PH_VER;
                        else if (label_cnt >= MAX_LABELS)
                        begin
                            err   = STS_DEEP;
                            stage = PH_DONE;
                        end
                    end
                end
                PH_VER:
                begin
                    if (p == hdr_end)
                    begin
                        if (b[7:4] == IPV4_VER)
                            cls = CLS_IPV4;
                        stage = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void note_request(evmc_in_t req);
            int        p;
            int        len;
            int        off;
            evmc_out_t r;
            p = byte_idx;
            parse_header_byte(p, req.data_byte);
            if (byte_idx < POS_MAX)
                byte_idx++;
            if (!req.last_byte)
                return;
            r = '0;
            if (p + 1 < 14)
                r.status = STS_SHORT;
            else
            begin
                if (stage != PH_DONE)
                begin
                    err = STS_TRUNC;
                    cls = CLS_NONE;
                end
                len = byte_idx;
                if (len > int'(LEN_CAP))
                    len = LEN_CAP;
                off = hdr_end;
                r.hook_class     = cls;
                r.payload_offset = 14'(off);
                r.payload_length = 14'((len > off) ? len - off : 0);
                r.ether_type     = frame_type;
                r.vlan_tagged    = vlan_seen;
                r.label_count    = label_cnt;
                r.status         = err;
            end
            status_cnt[r.status]++;
            if (r.vlan_tagged)
                vlan_cnt++;
            if (r.label_count != 0)
                mpls_cnt++;
            expected_q.push_back(r);
            clear_frame();
        endfunction

        function void check_result(evmc_out_t got);
            evmc_out_t want;
            bit        ok;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %h with no frame outstanding", got);
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            ok = got.hook_class === want.hook_class
                && got.payload_offset === want.payload_offset
                && got.payload_length === want.payload_length
                && got.ether_type === want.ether_type
                && got.vlan_tagged === want.vlan_tagged
                && got.label_count === want.label_count
                && got.status === want.status;
            if (!ok)
            begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: frame %0d exp/got: class %0d/%0d off %0d/%0d ",
                              "len %0d/%0d type %h/%h vlan %0b/%0b labels %0d/%0d ",
                              "status %0d/%0d"},
                             results_checked,
                             want.hook_class, got.hook_class,
                             want.payload_offset, got.payload_offset,
                             want.payload_length, got.payload_length,
                             want.ether_type, got.ether_type,
                             want.vlan_tagged, got.vlan_tagged,
                             want.label_count, got.label_count,
                             want.status, got.status);
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    evmc_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    evmc_out_t out_data;

    frame_scoreboard sb;
    logic [7:0]      frame_buf[$];
    bit              steady_flow  = 1'b0;
    bit              hold_request = 1'b0;
    int              bytes_sent   = 0;
    int              frames_sent  = 0;

    ethernet_vlan_mpls_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    task automatic push_bytes(int n);
        repeat (n) frame_buf.push_back(8'($urandom));
    endtask

    task automatic push_const(int n, logic [7:0] v);
        repeat (n) frame_buf.push_back(v);
    endtask

    task automatic push16(logic [15:0] v);
        frame_buf.push_back(v[15:8]);
        frame_buf.push_back(v[7:0]);
    endtask

    task automatic push_labels(int n, bit bottom);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            push_bytes(2);
            b    = 8'($urandom);
            b[0] = bottom && (i == n - 1);
            frame_buf.push_back(b);
            push_bytes(1);
        end
    endtask

    task automatic push_version(logic [3:0] nib);
        frame_buf.push_back({nib, 4'($urandom)});
    endtask

    task automatic cut_frame(int n);
        frame_buf = frame_buf[0:n-1];
    endtask

    task automatic send_byte(evmc_in_t req);
        while (!steady_flow && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(req);
        bytes_sent++;
    endtask

    task automatic send_frame();
        evmc_in_t req;
        foreach (frame_buf[i])
        begin
            req.data_byte = frame_buf[i];
            req.last_byte = (i == frame_buf.size() - 1);
            send_byte(req);
        end
        frame_buf = {};
        frames_sent++;
    endtask

    task automatic build_random_frame();
        int pick;
        int kind;
        pick = $urandom_range(99);
        if (pick < 6)
            push_bytes($urandom_range(1, 40));
        else if (pick < 10)
            push_bytes($urandom_range(1, 13));
        else
        begin
            push_bytes(12);
            if ($urandom_range(3) == 0)
            begin
                push16(TYPE_VLAN);
                push_bytes(2);
            end
            kind = $urandom_range(9);
            if (kind < 3)
                push16(TYPE_IPV4);
            else if (kind == 3)
                push16(TYPE_ARP);
            else if (kind < 8)
            begin
                push16($urandom_range(1) ? TYPE_MPLS : TYPE_MPLSM);
                if ($urandom_range(9) == 0)
                    push_labels($urandom_range(MAX_LABELS, MAX_LABELS + 2), 1'b0);
                else if ($urandom_range(14) == 0)
                    push_labels(MAX_LABELS, 1'b1);
                else
                    push_labels($urandom_range(1, 4), 1'b1);
                push_version($urandom_range(3) == 0 ? 4'($urandom) : IPV4_VER);
            end
            else if (kind == 8)
                push16(16'($urandom));
            else
                push16(TYPE_VLAN);
            push_bytes($urandom_range(0, 24));
            if ($urandom_range(99) < 15)
                cut_frame($urandom_range(1, frame_buf.size() - 1));
        end
    endtask

    task automatic run_directed();
        push_const(12, 8'hFF);
        push16(TYPE_IPV4);
        send_frame();
        push_const(12, 8'h00);
        push16(TYPE_ARP);
        push_bytes(28);
        send_frame();
        push_bytes(12);
        push16(16'hFFFF);
        push_bytes(5);
        send_frame();
        push_bytes(12);
        push16(16'h0000);
        send_frame();
        push_bytes(12);
        push16(TYPE_VLAN);
        push_bytes(2);
        push16(TYPE_IPV4);
        push_bytes(20);
        send_frame();
        push_bytes(12);
        push16(TYPE_VLAN);
        push_bytes(2);
        push16(TYPE_ARP);
        push_bytes(8);
        send_frame();
        // double tag: inner 0x8100 is not skipped
        push_bytes(12);
        push16(TYPE_VLAN);
        push_bytes(2);
        push16(TYPE_VLAN);
        push_bytes(6);
        send_frame();
        push_bytes(12);
        push16(TYPE_VLAN);
        push_bytes(2);
        push16(TYPE_MPLSM);
        push_labels(2, 1'b1);
        push_version(IPV4_VER);
        push_bytes(10);
        send_frame();
        push_bytes(12);
        push16(TYPE_MPLS);
        push_labels(1, 1'b1);
        push_version(4'h6);
        push_bytes(8);
        send_frame();
        push_bytes(12);
        push16(TYPE_MPLS);
        push_labels(MAX_LABELS, 1'b1);
        push_version(IPV4_VER);
        send_frame();
        // stack deeper than the bound
        push_bytes(12);
        push16(TYPE_MPLS);
        push_labels(MAX_LABELS + 1, 1'b0);
        push_version(IPV4_VER);
        push_bytes(4);
        send_frame();
        push_bytes(1);
        send_frame();
        push_bytes(13);
        send_frame();
        // VLAN tag cut short, once at the type and once inside the tag
        push_bytes(12);
        push16(TYPE_VLAN);
        send_frame();
        push_bytes(12);
        push16(TYPE_VLAN);
        push_bytes(2);
        send_frame();
        push_bytes(12);
        push16(TYPE_MPLS);
        push_labels(3, 1'b1);
        cut_frame(24);
        send_frame();
        // bottom label ends the frame, no version byte
        push_bytes(12);
        push16(TYPE_MPLSM);
        push_labels(1, 1'b1);
        send_frame();
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_ready    <= 1'b0;
            end
            else
                out_ready <= steady_flow || ($urandom_range(99) >= 33);
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                 cycles, sb.expected_q.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int start_frames;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();

        // output blocked while short frames keep arriving
        hold_request = 1'b1;
        repeat (12)
        begin
            push_bytes($urandom_range(1, 4));
            send_frame();
        end

        // first random frames run with no idling on either side
        start_frames = frames_sent;
        while (bytes_sent < ITEM_TARGET || frames_sent - start_frames < RANDOM_FRAMES)
        begin
            steady_flow = (frames_sent - start_frames < 4);
            build_random_frame();
            send_frame();
        end
        steady_flow = 1'b0;
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Streamed %0d frames in %0d bytes: %0d VLAN tagged, %0d with MPLS labels.",
                 frames_sent, bytes_sent, sb.vlan_cnt, sb.mpls_cnt);
        $display("Checked %0d results: %0d short, %0d truncated, %0d over-deep stacks.",
                 sb.results_checked, sb.status_cnt[STS_SHORT], sb.status_cnt[STS_TRUNC],
                 sb.status_cnt[STS_DEEP]);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
